// ----- rtl/hagc_pkg.sv -----
// hagc_pkg: shared constants, types and state encoding for the hang agc sample scaler
// used by hagc_serial_mul, hagc_serial_div and hang_agc_sample_scaler
// no dependencies
package hagc_pkg;

    // sample and field widths
    localparam int SAMPLE_BITS = 16;
    localparam int ABS_W       = SAMPLE_BITS + 1;
    localparam int LVL_W       = 15;
    localparam int OUT_W       = 24;
    localparam int HANG_W      = 3;
    localparam int DECAY_W     = 16;
    localparam int GAIN_W      = 24;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 3;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_FIELDS_W  = OUT_W + 2 * LVL_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    // agc target 0.29 in q0.16
    localparam int TARGET_W = 15;
    localparam logic [TARGET_W-1:0] AGC_TARGET = 15'd19005;

    // serial multiplier: a is parallel, b is consumed one bit per cycle
    localparam int MUL_A_W   = GAIN_W;
    localparam int MUL_B_W   = (ABS_W > LVL_W) ? ABS_W : LVL_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    // serial restoring divider
    localparam int DIV_NUM_W = ABS_W + TARGET_W;
    localparam int DIV_DEN_W = LVL_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // attack update: 9 * level + mag, divided by ten
    localparam int ATT_W = LVL_W + 4;
    localparam logic [DIV_DEN_W-1:0] DIV_TEN = DIV_DEN_W'(10);

    localparam int MAN_SHIFT = SAMPLE_BITS - 8;

    localparam logic [LVL_W-1:0]  LEVEL_MAX = {LVL_W{1'b1}};
    localparam logic [HANG_W-1:0] HANG_FAST = HANG_W'(1);
    localparam logic [HANG_W-1:0] HANG_SLOW = HANG_W'(6);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AUTO_MODE    = 3'd0,
        REG_FAST_HANG    = 3'd1,
        REG_BYPASS       = 3'd2,
        REG_DECAY_FACTOR = 3'd3,
        REG_LEVEL_FLOOR  = 3'd4,
        REG_MANUAL_GAIN  = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_DECL,
        ST_DECP,
        ST_FIN,
        ST_DONE
    } agc_state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_ctl_t;

endpackage

// ----- rtl/hagc_serial_mul.sv -----
// hagc_serial_mul: shift-add multiplier, one multiplier bit per cycle
// depends on hagc_pkg
module hagc_serial_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [hagc_pkg::MUL_A_W-1:0] a,
    input  logic [hagc_pkg::MUL_B_W-1:0] b,
    output logic                         busy,
    output logic [hagc_pkg::PROD_W-1:0]  prod
);
    import hagc_pkg::*;

    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [MUL_A_W:0]     sum;

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;

    // add the multiplicand into the upper part, then shift right
    assign sum = {1'b0, acc_reg[PROD_W-1:MUL_B_W]} + (b_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= MUL_CNT_W'(MUL_B_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - MUL_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy)
        begin
            b_reg   <= b_reg >> 1;
            acc_reg <= {sum, acc_reg[MUL_B_W-1:1]};
        end
    end

endmodule

// ----- rtl/hagc_serial_div.sv -----
// hagc_serial_div: restoring divider, one quotient bit per cycle, msb first
// depends on hagc_pkg
module hagc_serial_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hagc_pkg::div_ctl_t             ctl,
    input  logic [hagc_pkg::DIV_NUM_W-1:0] num,
    input  logic [hagc_pkg::DIV_DEN_W-1:0] den,
    output logic                           busy,
    output logic [hagc_pkg::DIV_NUM_W-1:0] quot
);
    import hagc_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quot_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;
    logic [DIV_DEN_W-1:0] rem_next;

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

    assign trial    = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fits     = (trial >= {1'b0, den_reg});
    assign rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.start)
        begin
            cnt_reg <= ctl.steps;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy)
        begin
            num_reg  <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[DIV_NUM_W-2:0], fits};
        end
    end

endmodule

// ----- rtl/hang_agc_sample_scaler.sv -----
// hang_agc_sample_scaler: agc with level and peak tracking and a hang counter
// top level; depends on hagc_pkg, hagc_serial_mul and hagc_serial_div
// processing time from input transaction to result is set by the
//   bit-serial multiplier (one bit a cycle) and the restoring divider
// the sequencer works on one sample at a time; a finished result waits in the
//   output register while the next sample is taken; bypass skips the arithmetic
// reset: asynchronous, active low; levels and hang cleared, registers to defaults
module hang_agc_sample_scaler (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_wr,
    input  logic [hagc_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [hagc_pkg::CFG_W-1:0]       cfg_data,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hagc_pkg::S_TDATA_W-1:0]   s_tdata,   // sample_in
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hagc_pkg::M_TDATA_W-1:0]   m_tdata    // sample_out, level_now, peak_now
);
    import hagc_pkg::*;

    // configuration registers
    logic               auto_mode_reg;
    logic               fast_hang_reg;
    logic               bypass_reg;
    logic [DECAY_W-1:0] decay_reg;
    logic [LVL_W-1:0]   floor_reg;
    logic [GAIN_W-1:0]  gain_reg;

    // tracking state
    logic [LVL_W-1:0]   level_reg;
    logic [LVL_W-1:0]   peak_reg;
    logic [HANG_W-1:0]  hang_reg;

    agc_state_t         state_reg;
    agc_state_t         state_next;

    // per-sample working registers
    logic               neg_reg;
    logic               attack_reg;
    logic [OUT_W-1:0]   result_reg;

    logic               out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    // input decode
    logic [ABS_W-1:0]   in_sext;
    logic               in_neg;
    logic [ABS_W-1:0]   in_abs;
    logic [LVL_W-1:0]   in_mag;
    logic               in_attack;
    logic [ATT_W-1:0]   att_sum;

    // divisor for automatic mode
    logic [LVL_W-1:0]     level_new;
    logic [LVL_W-1:0]     div_d;
    logic [DIV_DEN_W-1:0] den_scale;

    // arithmetic units
    logic                 mul_start;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic                 mul_busy;
    logic [PROD_W-1:0]    mul_prod;
    logic [LVL_W-1:0]     decay_out;

    div_ctl_t             div_ctl;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] div_q;

    // sequencer strobes
    logic take;
    logic pre_done;
    logic decl_done;
    logic decp_done;
    logic fin_done;
    logic out_load;

    // saturate a magnitude with its sign to the 24-bit output range
    function automatic logic [OUT_W-1:0] sat_out(input logic neg,
                                                 input logic [PROD_W-1:0] mag);
        logic [PROD_W-1:0] neg_mag;
        neg_mag = ~mag + PROD_W'(1);
        if (neg)
        begin
            if (mag > PROD_W'(1) << (OUT_W - 1))
                sat_out = {1'b1, {(OUT_W-1){1'b0}}};
            else
                sat_out = neg_mag[OUT_W-1:0];
        end
        else
        begin
            if (mag > (PROD_W'(1) << (OUT_W - 1)) - PROD_W'(1))
                sat_out = {1'b0, {(OUT_W-1){1'b1}}};
            else
                sat_out = mag[OUT_W-1:0];
        end
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // magnitude of the sample; the most negative value keeps its full size
    assign in_neg  = s_tdata[SAMPLE_BITS-1];
    assign in_sext = {s_tdata[SAMPLE_BITS-1], s_tdata[SAMPLE_BITS-1:0]};
    assign in_abs  = in_neg ? (~in_sext + ABS_W'(1)) : in_sext;
    // level tracking sees the magnitude clipped to the level range
    assign in_mag  = (MUL_B_W'(in_abs) > MUL_B_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                               : LVL_W'(in_abs);
    assign in_attack = (level_reg < in_mag);
    assign att_sum   = (ATT_W'(level_reg) << 3) + ATT_W'(level_reg) + ATT_W'(in_mag);

    // level after the attack step, ready once the divide by ten is done
    assign level_new = attack_reg ? div_q[LVL_W-1:0] : level_reg;

    always_comb
    begin
        div_d = (level_new > floor_reg) ? level_new : floor_reg;
        if (div_d == '0)
            div_d = LVL_W'(1);
    end

    // divisor is twice the level, so the quotient lands in q8.15
    assign den_scale = {div_d, 1'b0};
    assign decay_out = mul_prod[LVL_W+DECAY_W-1:DECAY_W];

    hagc_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    hagc_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_q)
    );

    // sequencer: attack divide (on an attack) and scale multiply run side by side, then
    // the scale divide (auto mode) runs in the background while the decay multiplies go
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_ctl    = '0;
        div_num    = '0;
        div_den    = '0;
        take       = 1'b0;
        pre_done   = 1'b0;
        decl_done  = 1'b0;
        decp_done  = 1'b0;
        fin_done   = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    take = 1'b1;
                    if (bypass_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mul_start = 1'b1;
                        mul_a     = auto_mode_reg ? MUL_A_W'(AGC_TARGET) : gain_reg;
                        mul_b     = MUL_B_W'(in_abs);
                        if (in_attack)
                        begin
                            div_ctl.start = 1'b1;
                            div_ctl.steps = DIV_CNT_W'(ATT_W);
                            div_num       = {att_sum, {(DIV_NUM_W-ATT_W){1'b0}}};
                            div_den       = DIV_TEN;
                        end
                        state_next = ST_PRE;
                    end
                end
            end

            ST_PRE:
            begin
                if (!mul_busy && !div_busy)
                begin
                    pre_done = 1'b1;
                    if (auto_mode_reg)
                    begin
                        div_ctl.start = 1'b1;
                        div_ctl.steps = DIV_CNT_W'(DIV_NUM_W);
                        div_num       = mul_prod[DIV_NUM_W-1:0];
                        div_den       = den_scale;
                    end
                    mul_start = 1'b1;
                    mul_a     = MUL_A_W'(decay_reg);
                    // the level decays only once the hang has run out
                    if (hang_reg == '0)
                    begin
                        mul_b      = MUL_B_W'(level_new);
                        state_next = ST_DECL;
                    end
                    else
                    begin
                        mul_b      = MUL_B_W'(peak_reg);
                        state_next = ST_DECP;
                    end
                end
            end

            ST_DECL:
            begin
                if (!mul_busy)
                begin
                    decl_done  = 1'b1;
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(decay_reg);
                    mul_b      = MUL_B_W'(peak_reg);
                    state_next = ST_DECP;
                end
            end

            ST_DECP:
            begin
                if (!mul_busy)
                begin
                    decp_done  = 1'b1;
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (!div_busy)
                begin
                    fin_done   = 1'b1;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_mode_reg <= 1'b1;
            fast_hang_reg <= 1'b0;
            bypass_reg    <= 1'b0;
            decay_reg     <= DECAY_W'(65470);
            floor_reg     <= LVL_W'(33);
            gain_reg      <= GAIN_W'(256);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_AUTO_MODE:    auto_mode_reg <= cfg_data[0];
                REG_FAST_HANG:    fast_hang_reg <= cfg_data[0];
                REG_BYPASS:       bypass_reg    <= cfg_data[0];
                REG_DECAY_FACTOR: decay_reg     <= cfg_data[DECAY_W-1:0];
                REG_LEVEL_FLOOR:  floor_reg     <= cfg_data[LVL_W-1:0];
                REG_MANUAL_GAIN:  gain_reg      <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // level, peak and hang tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            peak_reg  <= '0;
            hang_reg  <= '0;
        end
        else
        begin
            // attack: peak jumps to the magnitude and the hang reloads
            if (take && !bypass_reg && in_attack)
            begin
                peak_reg <= in_mag;
                hang_reg <= fast_hang_reg ? HANG_FAST : HANG_SLOW;
            end
            if (pre_done)
                level_reg <= level_new;
            if (decl_done)
                level_reg <= decay_out;
            if (decp_done)
            begin
                peak_reg <= decay_out;
                if (hang_reg != '0)
                    hang_reg <= hang_reg - HANG_W'(1);
            end
        end
    end

    // per-sample working values and the scaled result
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            neg_reg    <= in_neg;
            attack_reg <= in_attack && !bypass_reg;
            if (bypass_reg)
                result_reg <= OUT_W'($signed(s_tdata[SAMPLE_BITS-1:0]));
        end
        // manual gain product is final once the first multiply is done
        if (pre_done && !auto_mode_reg)
            result_reg <= sat_out(neg_reg, mul_prod >> MAN_SHIFT);
        if (fin_done && auto_mode_reg)
            result_reg <= sat_out(neg_reg, PROD_W'(div_q));
    end

    // output register, frees the sequencer while the result waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= {{M_PAD_W{1'b0}}, peak_reg, level_reg, result_reg};
    end

endmodule

// ----- verif/hagc_checker.sv -----
// hagc_checker: predicts every result of the hang agc sample scaler and compares it
// watches the config port and both stream channels; depends on hagc_pkg
module hagc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr,
    input  logic [hagc_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [hagc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [hagc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [hagc_pkg::M_TDATA_W-1:0]   m_tdata,
    output int                               errors,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hagc_pkg::*;

    localparam longint unsigned TARGET_Q16    = 19005;
    localparam int              GAIN_FRAC     = 8;
    localparam longint unsigned LEVEL_TOP     = 32767;
    localparam longint unsigned OUT_POS_LIMIT = 64'd8388607;
    localparam longint unsigned OUT_NEG_LIMIT = 64'd8388608;
    localparam logic [OUT_W-1:0]  OUT_MOST_POS = 24'h7FFFFF;
    localparam logic [OUT_W-1:0]  OUT_MOST_NEG = 24'h800000;
    localparam logic [HANG_W-1:0] HANG_RELOAD_FAST = 3'd1;
    localparam logic [HANG_W-1:0] HANG_RELOAD_SLOW = 3'd6;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd65470;
    localparam logic [LVL_W-1:0]   FLOOR_RESET = 15'd33;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd256;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [OUT_W-1:0] sample_out;
        logic [LVL_W-1:0] level_now;
        logic [LVL_W-1:0] peak_now;
    } agc_result_t;

    // register copy
    logic               auto_on;
    logic               fast_on;
    logic               bypass_on;
    logic [DECAY_W-1:0] decay_q16;
    logic [LVL_W-1:0]   min_div;
    logic [GAIN_W-1:0]  gain_q8;

    // tracking state
    logic [LVL_W-1:0]  level_est;
    logic [LVL_W-1:0]  peak_lvl;
    logic [HANG_W-1:0] hang_cnt;

    agc_result_t result_q[$];
    agc_result_t got;
    agc_result_t want;

    function automatic logic [OUT_W-1:0] clip_out(input logic neg, input longint unsigned m);
        if (neg)
            return (m > OUT_NEG_LIMIT) ? OUT_MOST_NEG : OUT_W'(64'd0 - m);
        return (m > OUT_POS_LIMIT) ? OUT_MOST_POS : OUT_W'(m);
    endfunction

    // advances the tracking state by one sample and returns the result it gives
    function automatic agc_result_t scale_sample(input logic signed [SAMPLE_BITS-1:0] x);
        agc_result_t     r;
        int              sv;
        logic            neg;
        longint unsigned absval;
        longint unsigned mag;
        longint unsigned lv;
        longint unsigned dvsr;
        sv     = x;
        neg    = (sv < 0);
        absval = neg ? -sv : sv;
        if (bypass_on)
        begin
            r.sample_out = OUT_W'(sv);
            r.level_now  = level_est;
            r.peak_now   = peak_lvl;
            return r;
        end
        mag = (absval > LEVEL_TOP) ? LEVEL_TOP : absval;
        lv  = level_est;
        // attack: level moves a tenth of the way, peak jumps, hang reloads
        if (lv < mag)
        begin
            lv       = (9 * lv + mag) / 10;
            peak_lvl = LVL_W'(mag);
            hang_cnt = fast_on ? HANG_RELOAD_FAST : HANG_RELOAD_SLOW;
        end
        if (auto_on)
        begin
            dvsr = (lv > min_div) ? lv : min_div;
            if (dvsr == 0)
                dvsr = 1;
            r.sample_out = clip_out(neg, (absval * TARGET_Q16) / (2 * dvsr));
        end
        else
            r.sample_out = clip_out(neg, (absval * gain_q8) >> GAIN_FRAC);
        if (hang_cnt == 0)
            lv = (lv * decay_q16) >> 16;
        peak_lvl = LVL_W'((64'(peak_lvl) * decay_q16) >> 16);
        if (hang_cnt != 0)
            hang_cnt = hang_cnt - 1'b1;
        level_est   = LVL_W'(lv);
        r.level_now = level_est;
        r.peak_now  = peak_lvl;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_on   = 1'b1;
            fast_on   = 1'b0;
            bypass_on = 1'b0;
            decay_q16 = DECAY_RESET;
            min_div   = FLOOR_RESET;
            gain_q8   = GAIN_RESET;
            level_est = '0;
            peak_lvl  = '0;
            hang_cnt  = '0;
            result_q.delete();
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_AUTO_MODE:    auto_on   = cfg_data[0];
                    REG_FAST_HANG:    fast_on   = cfg_data[0];
                    REG_BYPASS:       bypass_on = cfg_data[0];
                    REG_DECAY_FACTOR: decay_q16 = cfg_data[DECAY_W-1:0];
                    REG_LEVEL_FLOOR:  min_div   = cfg_data[LVL_W-1:0];
                    REG_MANUAL_GAIN:  gain_q8   = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: result transaction with none expected, tdata %h",
                                 $time, m_tdata);
                end
                else
                begin
                    want           = result_q.pop_front();
                    got.sample_out = m_tdata[OUT_W-1:0];
                    got.level_now  = m_tdata[OUT_W +: LVL_W];
                    got.peak_now   = m_tdata[OUT_W+LVL_W +: LVL_W];
                    if ((got.sample_out !== want.sample_out) ||
                        (got.level_now !== want.level_now) ||
                        (got.peak_now !== want.peak_now))
                    begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display("%0t: mismatch exp/got out %h/%h level %h/%h peak %h/%h",
                                     $time, want.sample_out, got.sample_out, want.level_now,
                                     got.level_now, want.peak_now, got.peak_now);
                    end
                end
            end
            if (s_tvalid && s_tready)
                result_q.push_back(scale_sample(s_tdata[SAMPLE_BITS-1:0]));
        end
        pending = result_q.size();
    end

endmodule

// ----- verif/tb_hang_agc_sample_scaler.sv -----
// tb_hang_agc_sample_scaler: stimulus and verdict for the hang agc sample scaler
// depends on hagc_pkg, the rtl of the block and hagc_checker
module tb_hang_agc_sample_scaler;
    timeunit 1ns;
    timeprecision 1ps;
    import hagc_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int RESET_LEN  = 4;
    localparam int GAP_MAX    = 13;
    localparam int PHASES     = 22;
    localparam int PHASE_LEN  = 50;
    // generous bound: ~1100 samples, each with at worst a gap, its work and a stall
    localparam int LIMIT      = 600000;
    // a bit more than the block's worst latency
    localparam int DRAIN      = 80;

    // indexes past the last register, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 16'sh8000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   cfg_wr   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx  = REG_AUTO_MODE;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;   // sample_in
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;         // sample_out, level_now, peak_now

    int errors;
    int pending;
    int cycle_count;
    // when set, neither side idles for the current phase
    bit steady = 1'b0;
    // amplitude of the current stretch of random samples
    int envelope = 1024;

    always #CLK_HALF clk = ~clk;

    hang_agc_sample_scaler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hagc_checker agc_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    // one register write per clock; called at a falling edge, returns at the next
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    // full register setup, sometimes with a stray write past the register file
    task automatic setup_regs(input logic am, input logic fh, input logic bp,
                              input logic [DECAY_W-1:0] dk, input logic [LVL_W-1:0] fl,
                              input logic [GAIN_W-1:0] gn);
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
        write_reg(REG_AUTO_MODE, CFG_W'(am));
        write_reg(REG_FAST_HANG, CFG_W'(fh));
        write_reg(REG_BYPASS, CFG_W'(bp));
        write_reg(REG_DECAY_FACTOR, CFG_W'(dk));
        write_reg(REG_LEVEL_FLOOR, CFG_W'(fl));
        write_reg(REG_MANUAL_GAIN, CFG_W'(gn));
        cfg_wr <= 1'b0;
    endtask

    // one input transaction, preceded by a random gap unless the phase is steady
    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] x);
        int gap;
        gap = steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= S_TDATA_W'(x);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!(s_tvalid && s_tready))
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending and wait until every predicted result has come back;
    // every sample gives a result, so the block is idle after this
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // mostly enveloped audio so the level, hang and decay get exercised,
    // with some full-scale noise and the range extremes mixed in
    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
        int pick;
        int v;
        pick = $urandom_range(0, 19);
        if ($urandom_range(0, 7) == 0)
            envelope = 1 << $urandom_range(0, 15);
        if (pick == 0)
        begin
            case ($urandom_range(0, 4))
                0: return SMP_MIN;
                1: return SMP_MAX;
                2: return '0;
                3: return -16'sd1;
                default: return 16'sd1;
            endcase
        end
        if (pick <= 3)
            return SAMPLE_BITS'($urandom);
        v = $urandom_range(0, 2 * envelope) - envelope;
        if (v > 32767)
            v = 32767;
        return SAMPLE_BITS'(v);
    endfunction

    // random register set with the extremes drawn often
    task automatic shuffle_regs();
        logic [DECAY_W-1:0] dk;
        logic [LVL_W-1:0]   fl;
        logic [GAIN_W-1:0]  gn;
        case ($urandom_range(0, 4))
            0: dk = '0;
            1: dk = '1;
            2: dk = DECAY_W'($urandom);
            default: dk = DECAY_W'($urandom_range(60000, 65535));
        endcase
        case ($urandom_range(0, 5))
            0: fl = 15'd1;
            1: fl = '1;
            2: fl = LVL_W'($urandom);
            3: fl = LVL_W'($urandom_range(0, 64));
            default: fl = LVL_W'($urandom_range(1, 3000));
        endcase
        case ($urandom_range(0, 4))
            0: gn = '0;
            1: gn = '1;
            2: gn = GAIN_W'($urandom);
            default: gn = GAIN_W'($urandom_range(0, 4096));
        endcase
        setup_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 7) == 0, dk, fl, gn);
    endtask

    // result side: random stall before each result, none in steady phases
    initial
    begin
        int stall;
        @(negedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, GAP_MAX);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
            @(negedge clk);
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int k;
        int j;
        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // registers as left by reset: auto mode, slow hang, default floor and decay
        push_sample('0);
        push_sample(SMP_MAX);
        push_sample(SMP_MIN);
        push_sample(-16'sd1);
        push_sample(16'sd1);
        push_sample(16'sd100);
        push_sample(-16'sd16384);
        push_sample('0);
        settle();

        // zero floor and zero decay factor: divisor falls back to one once the level is zero;
        // stray writes past the register file must change nothing
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, CFG_W'(1));
        setup_regs(1'b1, 1'b1, 1'b0, '0, '0, '0);
        push_sample(16'sd5);
        push_sample(-16'sd9);
        push_sample('0);
        push_sample(16'sd3);
        settle();

        // manual mode at full gain: both saturation limits
        setup_regs(1'b0, 1'b0, 1'b0, '1, '1, '1);
        push_sample(SMP_MAX);
        push_sample(SMP_MIN);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        settle();

        // bypass: samples pass through, tracking frozen
        setup_regs(1'b0, 1'b0, 1'b1, '1, '1, '1);
        push_sample(SMP_MIN);
        push_sample(SMP_MAX);
        push_sample(16'sd12345);
        settle();

        // auto mode with the largest floor
        setup_regs(1'b1, 1'b0, 1'b0, 16'd65470, '1, '0);
        push_sample(SMP_MIN);
        push_sample(SMP_MAX);
        settle();

        // manual mode with zero gain
        setup_regs(1'b0, 1'b1, 1'b0, 16'd65000, 15'd1, '0);
        push_sample(SMP_MIN);
        push_sample(16'sd20000);
        settle();

        // random phases, each under its own register set
        for (k = 0; k < PHASES; k++)
        begin
            steady = ($urandom_range(0, 3) == 0);
            shuffle_regs();
            for (j = 0; j < PHASE_LEN; j++)
                push_sample(draw_sample());
            settle();
        end

        repeat (DRAIN) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
